// ----- design/ms44_pkg.sv -----
// ----------------------------------------------------------------------------
// ms44_pkg
// Shared types, command/status structs and single-precision float helpers
// for the 4x4 matrix stack.
// ----------------------------------------------------------------------------
package ms44_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_WR_OPND = 3'd0;
  localparam logic [2:0] OP_PUSH    = 3'd1;
  localparam logic [2:0] OP_POP     = 3'd2;
  localparam logic [2:0] OP_IDENT   = 3'd3;
  localparam logic [2:0] OP_LOAD    = 3'd4;
  localparam logic [2:0] OP_MUL_TO  = 3'd5;
  localparam logic [2:0] OP_MUL_OT  = 3'd6;

  localparam int          MAT_WORDS  = 16;
  localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
  localparam logic [31:0] FP_DEF_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QNAN_B  = 32'h0040_0000;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] top_element;
    logic [3:0]  level;
    logic        overflow;
  } out_item_t;

  // source of a stack memory write
  typedef enum logic [1:0] {
    SRC_RD,
    SRC_IDENT,
    SRC_OPND,
    SRC_TEMP
  } wr_src_t;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       opnd_we;
    logic       set_ovf;
    logic       lvl_inc;
    logic       lvl_dec;
    logic       rd_en;
    logic       rd_rb;
    logic [3:0] rd_idx;
    logic       wr_en;
    logic       wr_up;
    logic [3:0] wr_idx;
    wr_src_t    wr_src;
    logic [3:0] opnd_idx;
    logic       a_is_top;
    logic       mul1;
    logic       mul2;
    logic       add1;
    logic       add2;
    logic       acc_first;
    logic       temp_we;
    logic       out_load;
  } ms44_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       lvl_full;
    logic       lvl_zero;
  } ms44_sts_t;

  // float value between the two halves of an operation
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               s;
    logic signed [11:0] e;
    logic [48:0]        m;
  } fp_mid_t;

  function automatic logic fp_is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  // normalize and round to nearest even; m has its units bit at 47,
  // e is the biased exponent of that units bit
  function automatic logic [31:0] fp_pack(input logic s, input logic signed [11:0] e,
                                          input logic [48:0] m);
    int           p;
    int           ef;
    int           d;
    int           rs;
    logic [97:0]  tmp;
    logic [48:0]  mm;
    logic         st;
    logic         inc;
    logic [7:0]   ef8;
    logic [30:0]  r;
    p   = 0;
    st  = 1'b0;
    mm  = m;
    tmp = '0;
    rs  = 0;
    for (int b = 0; b < 49; b++) begin
      if (m[b]) p = b;
    end
    ef = int'(e) + p - 47;
    if (m == 49'd0) return {s, 31'd0};
    if (ef >= 255) return {s, 8'hFF, 23'd0};
    if (ef < 1) ef = 1;
    d = int'(e) - ef;
    if (d >= 0) begin
      mm = m << d;
    end else begin
      rs = -d;
      if (rs > 98) rs = 98;
      tmp = {m, 49'd0} >> rs;
      mm  = tmp[97:49];
      st  = |tmp[48:0];
    end
    st  = st | (|mm[22:0]);
    inc = mm[23] & (st | mm[24]);
    ef8 = mm[47] ? 8'(ef) : 8'd0;
    r   = {ef8, mm[46:24]} + 31'(inc);
    return {s, r};
  endfunction

  // first half of a multiply: special cases and the mantissa product
  function automatic fp_mid_t fp_mul1(input logic [31:0] a, input logic [31:0] b);
    fp_mid_t     r;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] pr;
    logic        az;
    logic        bz;
    r  = '0;
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    az = a[30:0] == 31'd0;
    bz = b[30:0] == 31'd0;
    pr = ma * mb;
    r.s = a[31] ^ b[31];
    r.e = 12'(a[30:23] == 8'd0 ? 8'd1 : a[30:23]) + 12'(b[30:23] == 8'd0 ? 8'd1 : b[30:23])
          - 12'sd127;
    r.m = {pr, 1'b0};
    if (fp_is_nan(a)) begin
      r.spec = 1'b1; r.spec_val = a | FP_QNAN_B;
    end else if (fp_is_nan(b)) begin
      r.spec = 1'b1; r.spec_val = b | FP_QNAN_B;
    end else if ((fp_is_inf(a) && bz) || (fp_is_inf(b) && az)) begin
      r.spec = 1'b1; r.spec_val = FP_DEF_NAN;
    end else if (fp_is_inf(a) || fp_is_inf(b)) begin
      r.spec = 1'b1; r.spec_val = {r.s, 8'hFF, 23'd0};
    end
    return r;
  endfunction

  // first half of an add: special cases, alignment and the mantissa sum
  function automatic fp_mid_t fp_add1(input logic [31:0] a, input logic [31:0] b);
    fp_mid_t     r;
    logic [31:0] bg;
    logic [31:0] sm;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [71:0] tmp;
    logic [47:0] al;
    logic [48:0] bw;
    r  = '0;
    if (a[30:0] >= b[30:0]) begin
      bg = a; sm = b;
    end else begin
      bg = b; sm = a;
    end
    eb  = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
    es  = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d   = eb - es;
    tmp = {sm[30:23] != 8'd0, sm[22:0], 48'd0} >> d;
    al  = tmp[71:24] | 48'(|tmp[23:0]);
    bw  = {1'b0, bg[30:23] != 8'd0, bg[22:0], 24'd0};
    if (a[31] == b[31]) r.m = bw + {1'b0, al};
    else                r.m = bw - {1'b0, al};
    r.s = (r.m == 49'd0) ? (a[31] & b[31]) : bg[31];
    r.e = 12'(eb);
    if (fp_is_nan(a)) begin
      r.spec = 1'b1; r.spec_val = a | FP_QNAN_B;
    end else if (fp_is_nan(b)) begin
      r.spec = 1'b1; r.spec_val = b | FP_QNAN_B;
    end else if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])) begin
      r.spec = 1'b1; r.spec_val = FP_DEF_NAN;
    end else if (fp_is_inf(a)) begin
      r.spec = 1'b1; r.spec_val = a;
    end else if (fp_is_inf(b)) begin
      r.spec = 1'b1; r.spec_val = b;
    end
    return r;
  endfunction

  // second half of either operation
  function automatic logic [31:0] fp_fin(input fp_mid_t x);
    return x.spec ? x.spec_val : fp_pack(x.s, x.e, x.m);
  endfunction

endpackage

// ----- design/ms44_if.sv -----
// ----------------------------------------------------------------------------
// ms44 channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ms44_in_if ();
  logic               valid;
  logic               ready;
  ms44_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ms44_out_if ();
  logic                valid;
  logic                ready;
  ms44_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/ms44_ctrl.sv -----
// ----------------------------------------------------------------------------
// ms44_ctrl
// Sequencer for the matrix stack: walks copies, fills and the 64 products
// of a matrix multiply through the shared float unit.
// ----------------------------------------------------------------------------
module ms44_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ms44_pkg::ms44_cmd_t cmd,
  input  ms44_pkg::ms44_sts_t sts
);
  import ms44_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_CP_RD,
    S_CP_WR,
    S_ID_WR,
    S_LD_WR,
    S_MM_RD,
    S_MM_MUL1,
    S_MM_MUL2,
    S_MM_ADD1,
    S_MM_ADD2,
    S_TMP_WR,
    S_RB_RD,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_to;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign is_to     = (sts.op == OP_MUL_TO);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.wr_src    = SRC_RD;
    cmd.wr_idx    = cnt_r;
    cmd.a_is_top  = is_to;
    // top*operand reads top row-wise, operand*top reads top column-wise
    cmd.rd_idx    = is_to ? {cnt_r[3:2], k_r} : {k_r, cnt_r[1:0]};
    cmd.opnd_idx  = is_to ? {k_r, cnt_r[1:0]} : {cnt_r[3:2], k_r};
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        cnt_nxt   = '0;
        k_nxt     = '0;
        state_nxt = S_RB_RD;
        case (sts.op)
          OP_WR_OPND: cmd.opnd_we = 1'b1;
          OP_PUSH: begin
            if (sts.lvl_full) cmd.set_ovf = 1'b1;
            else              state_nxt = S_CP_RD;
          end
          OP_POP:    cmd.lvl_dec = !sts.lvl_zero;
          OP_IDENT:  state_nxt = S_ID_WR;
          OP_LOAD:   state_nxt = S_LD_WR;
          OP_MUL_TO: state_nxt = S_MM_RD;
          OP_MUL_OT: state_nxt = S_MM_RD;
          default:   state_nxt = S_RB_RD;
        endcase
      end
      // push: copy top one level up, word by word
      S_CP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = cnt_r;
        state_nxt  = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_up  = 1'b1;
        cmd.wr_src = SRC_RD;
        cnt_nxt    = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          cmd.lvl_inc = 1'b1;
          state_nxt   = S_RB_RD;
        end else begin
          state_nxt = S_CP_RD;
        end
      end
      S_ID_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = SRC_IDENT;
        cnt_nxt    = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = S_RB_RD;
      end
      S_LD_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_src   = SRC_OPND;
        cmd.opnd_idx = cnt_r;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = S_RB_RD;
      end
      // one product term per pass
      S_MM_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_MM_MUL1;
      end
      S_MM_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MM_MUL2;
      end
      S_MM_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MM_ADD1;
      end
      S_MM_ADD1: begin
        if (k_r == 2'd0) begin
          cmd.acc_first = 1'b1;
          k_nxt         = 2'd1;
          state_nxt     = S_MM_RD;
        end else begin
          cmd.add1  = 1'b1;
          state_nxt = S_MM_ADD2;
        end
      end
      S_MM_ADD2: begin
        cmd.add2  = 1'b1;
        k_nxt     = k_r + 2'd1;
        state_nxt = S_MM_RD;
        if (k_r == 2'd3) begin
          cmd.temp_we = 1'b1;
          cnt_nxt     = cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_nxt = S_TMP_WR;
        end
      end
      // write the finished product back over the top
      S_TMP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = SRC_TEMP;
        cnt_nxt    = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = S_RB_RD;
      end
      S_RB_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_rb = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/ms44_dpath.sv -----
// ----------------------------------------------------------------------------
// ms44_dpath
// Stack memory, operand matrix, level register, the shared two-step float
// unit and the result register.
// ----------------------------------------------------------------------------
module ms44_dpath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ms44_pkg::in_item_t  in_data,
  input  ms44_pkg::ms44_cmd_t cmd,
  output ms44_pkg::ms44_sts_t sts,
  output ms44_pkg::out_item_t out_data
);
  import ms44_pkg::*;

  localparam int LW  = $clog2(STACK_DEPTH);
  localparam int AW  = LW + 4;
  localparam int MEM = STACK_DEPTH * MAT_WORDS;

  logic [31:0]   mem [MEM];
  logic [31:0]   mem_q_r;
  logic [3:0]    rd_idx_r;
  logic          rd_lvl0_r;
  logic [15:0]   vld0_r;
  logic [LW-1:0] level_r;
  logic [LW-1:0] wr_lvl;
  logic [AW-1:0] rd_addr;
  logic [3:0]    rd_idx;
  logic [31:0]   rd_word;
  logic [31:0]   wr_data;
  logic [31:0]   opnd_r [MAT_WORDS];
  logic [31:0]   temp_r [MAT_WORDS];
  logic [31:0]   opnd_word;
  logic [31:0]   fin;
  fp_mid_t       mid_r;
  logic [31:0]   prod_r;
  logic [31:0]   acc_r;
  in_item_t      item_r;
  logic          ovf_r;
  out_item_t     out_r;

  assign sts.op       = item_r.op;
  assign sts.lvl_full = (level_r == LW'(STACK_DEPTH - 1));
  assign sts.lvl_zero = (level_r == '0);
  assign out_data     = out_r;

  function automatic logic [31:0] ident_word(input logic [3:0] idx);
    return (idx[3:2] == idx[1:0]) ? FP_ONE : 32'd0;
  endfunction

  // read and write addressing
  assign rd_idx    = cmd.rd_rb ? {item_r.row, item_r.col} : cmd.rd_idx;
  assign rd_addr   = {level_r, rd_idx};
  assign wr_lvl    = cmd.wr_up ? level_r + LW'(1) : level_r;
  assign opnd_word = opnd_r[cmd.opnd_idx];
  // level zero reads identity until each word has been written
  assign rd_word   = (rd_lvl0_r && !vld0_r[rd_idx_r]) ? ident_word(rd_idx_r) : mem_q_r;
  assign fin       = fp_fin(mid_r);

  always_comb begin
    case (cmd.wr_src)
      SRC_RD:    wr_data = rd_word;
      SRC_IDENT: wr_data = ident_word(cmd.wr_idx);
      SRC_OPND:  wr_data = opnd_word;
      SRC_TEMP:  wr_data = temp_r[cmd.wr_idx];
      default:   wr_data = rd_word;
    endcase
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[{wr_lvl, cmd.wr_idx}] <= wr_data;
    if (cmd.rd_en) begin
      mem_q_r   <= mem[rd_addr];
      rd_idx_r  <= rd_idx;
      rd_lvl0_r <= (level_r == '0);
    end
  end

  // control state: level and level-zero valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      vld0_r  <= '0;
    end else begin
      if (cmd.lvl_inc)      level_r <= level_r + LW'(1);
      else if (cmd.lvl_dec) level_r <= level_r - LW'(1);
      if (cmd.wr_en && (wr_lvl == '0)) vld0_r[cmd.wr_idx] <= 1'b1;
    end
  end

  // item, operand, float unit and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_data;
      ovf_r  <= 1'b0;
    end
    if (cmd.set_ovf) ovf_r <= 1'b1;
    if (cmd.opnd_we) opnd_r[{item_r.row, item_r.col}] <= item_r.value;
    if (cmd.mul1) begin
      if (cmd.a_is_top) mid_r <= fp_mul1(rd_word, opnd_word);
      else              mid_r <= fp_mul1(opnd_word, rd_word);
    end
    if (cmd.add1)      mid_r  <= fp_add1(acc_r, prod_r);
    if (cmd.mul2)      prod_r <= fin;
    if (cmd.acc_first) acc_r  <= prod_r;
    if (cmd.add2)      acc_r  <= fin;
    if (cmd.temp_we)   temp_r[cmd.wr_idx] <= fin;
    if (cmd.out_load) begin
      out_r.top_element <= rd_word;
      out_r.level       <= 4'(level_r);
      out_r.overflow    <= ovf_r;
    end
  end

endmodule

// ----- design/matrix_stack_4x4_unit.sv -----
// Sequence: op 0, pop and unused codes go straight from dispatch to the readback; push copies 16 words;
//   identity and load write 16 words; the two matrix products run 64 terms through one float unit.
// Throughput: one item at a time; the next item is taken once the result is
//   registered, while that result may still wait for the sink.
// Reset: synchronous active-low rst_n; stack level 0, level zero reads identity,
//   other levels and the operand matrix are undefined until written.
// ----------------------------------------------------------------------------
// matrix_stack_4x4_unit
// Stack of 4x4 single-precision matrices with push, pop, identity, load and
// the two matrix products, returning one top element per item.
// ----------------------------------------------------------------------------
module matrix_stack_4x4_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ms44_in_if.sink    in_ch,
  ms44_out_if.source out_ch
);
  import ms44_pkg::*;

  ms44_cmd_t cmd;
  ms44_sts_t sts;

  // sequencer
  ms44_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage and float unit
  ms44_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_ch.data)
  );

endmodule

// ----- tb/sv/ms44_checker.sv -----
// ----------------------------------------------------------------------------
// ms44_checker
// Watches both channels of the matrix stack, keeps its own copy of the stack
// and the operand matrix, predicts the readback of every accepted item and
// compares each returned item field by field in order.
// ----------------------------------------------------------------------------
module ms44_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fin,
  ms44_in_if         in_mon,
  ms44_out_if        out_mon,
  output int         n_fail
);
  import ms44_pkg::*;

  localparam int DEPTH = 16;

  logic [31:0] stack_mem [DEPTH][MAT_WORDS];
  logic [31:0] opnd_mat [MAT_WORDS];
  logic [3:0]  cur_level;
  out_item_t   readback_q [$];
  int          mismatches;

  // float bits to double, exact
  function automatic real f32_to_dbl(input logic [31:0] x);
    logic [63:0] d;
    int          p;
    p = 0;
    if (x[30:0] == 31'd0) begin
      d = {x[31], 63'd0};
    end else if (x[30:23] == 8'hFF) begin
      d = {x[31], 11'h7FF, x[22:0], 29'd0};
    end else if (x[30:23] == 8'd0) begin
      for (int b = 0; b < 23; b++) if (x[b]) p = b;
      d = {x[31], 11'(p - 149 + 1023), 52'((64'(x[22:0]) << (52 - p)))};
    end else begin
      d = {x[31], 11'(int'(x[30:23]) - 127 + 1023), x[22:0], 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  // double to float bits, round to nearest even
  function automatic logic [31:0] dbl_to_f32(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    logic        half;
    logic        stick;
    logic [30:0] res;
    int          e;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    e = int'(d[62:52]) - 1023 + 127;
    if (e >= 255) return {d[63], 8'hFF, 23'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    sh  = (e >= 1) ? 29 : 29 + 1 - e;
    if (sh >= 64) begin
      kept = 64'd0; half = 1'b0; stick = 1'b1;
    end else begin
      kept  = sig >> sh;
      half  = sig[sh-1];
      stick = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
    end
    res = (e >= 1) ? {8'(e), kept[22:0]} : kept[30:0];
    res = res + 31'(half & (stick | kept[0]));
    return {d[63], res};
  endfunction

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 23'd0;
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] == 23'd0;
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a)) return a | 32'h0040_0000;
    if (is_nan(b)) return b | 32'h0040_0000;
    if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
      return 32'hFFC0_0000;
    return dbl_to_f32(f32_to_dbl(a) * f32_to_dbl(b));
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a)) return a | 32'h0040_0000;
    if (is_nan(b)) return b | 32'h0040_0000;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return 32'hFFC0_0000;
    return dbl_to_f32(f32_to_dbl(a) + f32_to_dbl(b));
  endfunction

  // product of two 4x4 matrices, terms summed in k order
  function automatic void mat_product(input logic [31:0] a [MAT_WORDS],
                                      input logic [31:0] b [MAT_WORDS],
                                      output logic [31:0] p [MAT_WORDS]);
    logic [31:0] acc;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = f32_mul(a[i*4], b[j]);
        for (int k = 1; k < 4; k++) acc = f32_add(acc, f32_mul(a[i*4+k], b[k*4+j]));
        p[i*4+j] = acc;
      end
    end
  endfunction

  // apply one item to the shadow stack and queue the expected readback
  task automatic stack_apply(input in_item_t it);
    logic [31:0] top [MAT_WORDS];
    logic [31:0] prod [MAT_WORDS];
    out_item_t   exp_it;
    exp_it = '0;
    for (int w = 0; w < MAT_WORDS; w++) top[w] = stack_mem[cur_level][w];
    case (it.op)
      OP_WR_OPND: opnd_mat[{it.row, it.col}] = it.value;
      OP_PUSH: begin
        if (cur_level == 4'(DEPTH - 1)) begin
          exp_it.overflow = 1'b1;
        end else begin
          for (int w = 0; w < MAT_WORDS; w++) stack_mem[cur_level + 4'd1][w] = top[w];
          cur_level = cur_level + 4'd1;
        end
      end
      OP_POP: if (cur_level != 4'd0) cur_level = cur_level - 4'd1;
      OP_IDENT: for (int w = 0; w < MAT_WORDS; w++)
        stack_mem[cur_level][w] = ((w >> 2) == (w & 3)) ? FP_ONE : 32'd0;
      OP_LOAD: for (int w = 0; w < MAT_WORDS; w++) stack_mem[cur_level][w] = opnd_mat[w];
      OP_MUL_TO: begin
        mat_product(top, opnd_mat, prod);
        for (int w = 0; w < MAT_WORDS; w++) stack_mem[cur_level][w] = prod[w];
      end
      OP_MUL_OT: begin
        mat_product(opnd_mat, top, prod);
        for (int w = 0; w < MAT_WORDS; w++) stack_mem[cur_level][w] = prod[w];
      end
      default: ;
    endcase
    exp_it.top_element = stack_mem[cur_level][{it.row, it.col}];
    exp_it.level       = cur_level;
    readback_q.push_back(exp_it);
  endtask

  // prediction on input accepts, comparison on output accepts
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cur_level  = 4'd0;
      mismatches = 0;
      readback_q.delete();
      for (int w = 0; w < MAT_WORDS; w++) begin
        stack_mem[0][w] = ((w >> 2) == (w & 3)) ? FP_ONE : 32'd0;
        opnd_mat[w] = 32'd0;
      end
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (readback_q.size() == 0) begin
          $display("%0t: result item with nothing expected: %h", $time, out_mon.data);
          mismatches++;
        end else begin
          want = readback_q.pop_front();
          if (want.top_element !== out_mon.data.top_element) begin
            $display("%0t: top_element expected %h actual %h", $time, want.top_element,
                     out_mon.data.top_element);
            mismatches++;
          end
          if (want.level !== out_mon.data.level) begin
            $display("%0t: level expected %0d actual %0d", $time, want.level,
                     out_mon.data.level);
            mismatches++;
          end
          if (want.overflow !== out_mon.data.overflow) begin
            $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                     out_mon.data.overflow);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) stack_apply(in_mon.data);
    end
    n_fail <= mismatches + (fin ? readback_q.size() : 0);
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the matrix stack: directed corner items, then
// random items in bursts against a stalling receiver, checked by ms44_checker.
// ----------------------------------------------------------------------------
module tb;
  import ms44_pkg::*;

  localparam int N_RANDOM    = 1000;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic fin;
  int   n_fail;
  int   n_sent;
  int   n_recv;
  int   cycles;
  int   burst_left;
  logic start_hold;
  logic hold_done;
  int   hold_cnt;
  int   mode_cnt;
  int   rx_mode;

  ms44_in_if  in_ch ();
  ms44_out_if out_ch ();

  matrix_stack_4x4_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  ms44_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .fin     (fin),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .n_fail  (n_fail)
  );

  // clock
  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // run limit
  always @(posedge clk) begin
    if (!rst_n) cycles <= 0;
    else        cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // count returned items
  always @(posedge clk) begin
    if (!rst_n)                              n_recv <= 0;
    else if (out_ch.valid && out_ch.ready)   n_recv <= n_recv + 1;
  end

  // receiver: stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= 0;
      hold_done    <= 1'b0;
      mode_cnt     <= 0;
      rx_mode      <= 0;
    end else if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= hold_cnt - 1;
    end else if (start_hold && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= 3000;
      hold_done    <= 1'b1;
    end else begin
      if (mode_cnt == 0) begin
        mode_cnt <= $urandom_range(200, 20);
        rx_mode  <= $urandom_range(2, 0);
      end else begin
        mode_cnt <= mode_cnt - 1;
      end
      case (rx_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= $urandom_range(1, 0);
        default: out_ch.ready <= ($urandom_range(7, 0) == 0);
      endcase
    end
  end

  // operand element bits: mostly moderate floats, some subnormals, specials and raw bits
  function automatic logic [31:0] rand_value();
    int pick;
    pick = $urandom_range(19, 0);
    if (pick == 0) return $urandom;
    if (pick == 1) return {1'($urandom), 8'd0, 23'($urandom)};
    if (pick == 2) begin
      case ($urandom_range(3, 0))
        0:       return 32'h0000_0000;
        1:       return 32'h8000_0000;
        2:       return 32'h7F80_0000;
        default: return 32'h7F7F_FFFF;
      endcase
    end
    return {1'($urandom), 8'($urandom_range(134, 120)), 23'($urandom)};
  endfunction

  // offer one item and hold it until accepted; gaps between bursts
  task automatic send_item(input logic [2:0] op, input logic [31:0] v);
    in_item_t it;
    it.op    = op;
    it.row   = 2'($urandom);
    it.col   = 2'($urandom);
    it.value = v;
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    n_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(30, 1);
      if ($urandom_range(2, 0) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(40, 1)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_op(input logic [2:0] op);
    send_item(op, $urandom);
  endtask

  initial begin
    logic [31:0] corner [8];
    int          pick;
    corner = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
               32'h7FC0_0001, 32'h0000_0001, 32'h7F7F_FFFF, 32'hFFFF_FFFF};
    rst_n       = 1'b0;
    fin         = 1'b0;
    start_hold  = 1'b0;
    n_sent      = 0;
    burst_left  = 5;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operand element written, corners among them
    for (int w = 0; w < MAT_WORDS; w++) begin
      in_item_t it;
      it.op    = OP_WR_OPND;
      it.row   = 2'(w >> 2);
      it.col   = 2'(w);
      it.value = (w < 8) ? corner[w] : rand_value();
      in_ch.data  <= it;
      in_ch.valid <= 1'b1;
      @(negedge clk);
      while (!in_ch.ready) @(negedge clk);
      @(posedge clk);
      n_sent++;
    end
    // pop at the bottom, then each operation once, unused code too
    send_op(OP_POP);
    send_op(OP_MUL_TO);
    send_op(OP_PUSH);
    send_op(OP_LOAD);
    send_op(OP_MUL_OT);
    send_op(OP_IDENT);
    send_op(OP_POP);
    send_op(3'd7);

    // random: mostly well-formed traffic with random content
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) start_hold = 1'b1;
      pick = $urandom_range(99, 0);
      if (pick < 40)      send_item(OP_WR_OPND, rand_value());
      else if (pick < 58) send_op(OP_PUSH);
      else if (pick < 70) send_op(OP_POP);
      else if (pick < 75) send_op(OP_IDENT);
      else if (pick < 81) send_op(OP_LOAD);
      else if (pick < 89) send_op(OP_MUL_TO);
      else if (pick < 97) send_op(OP_MUL_OT);
      else                send_op(3'd7);
    end
    in_ch.valid <= 1'b0;

    // drain, then let the block settle
    while (n_recv != n_sent) @(posedge clk);
    repeat (400) @(posedge clk);
    fin <= 1'b1;
    repeat (2) @(posedge clk);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
